// ===== src/asos_pkg.sv =====
// Package for the audio sample offset shifter: payload structs, internal
// control structs and sizing constants. No dependencies.
package asos_pkg;

  // Bytes in one CD audio sector
  localparam int SECTOR_BYTES = 2352;
  // Depth of the byte delay memory (power of two)
  localparam int DELAY_DEPTH  = 8192;
  localparam int ADDR_W       = $clog2(DELAY_DEPTH);

  // Offset register, byte-shift magnitude, run position, sector count and owed-zero count widths
  localparam int OFS_W  = 12;
  localparam int MAG_W  = OFS_W + 2;
  localparam int POS_W  = 31;
  localparam int SEC_W  = 19;
  localparam int ZERO_W = 14;

  // Output queue sizing
  localparam int FIFO_DEPTH = 3;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Input op codes
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic             op;
    logic [7:0]       sample_byte;
    logic [SEC_W-1:0] run_sectors;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // Delay memory access for one accepted byte
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // Result under construction, registered in the cycle after the accept
  typedef struct packed {
    logic       valid;
    logic       use_mem;
    logic [7:0] data;
    logic       last;
  } stage_t;

endpackage

// ===== src/asos_delay_ram.sv =====
// Byte delay memory: one write port, one read port, registered read data,
// read-first on a same-address collision. Depends on asos_pkg.
module asos_delay_ram
  import asos_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DELAY_DEPTH];
  logic [7:0] rdata_r;

  // Read returns the old contents when the write hits the same entry
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/asos_out_fifo.sv =====
// Small output queue that decouples the result side from the pipeline.
// Depends on asos_pkg.
module asos_out_fifo
  import asos_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  out_item_t        push_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  output logic [CNT_W-1:0] count
);

  out_item_t        q_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;

  assign out_valid = (count_r != '0);
  assign out_data  = q_r[rd_ptr_r];
  assign count     = count_r;
  assign pop       = out_valid && !out_stall;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/asos_ctrl.sv =====
// Run control: offset register, run bookkeeping, delay memory addressing and
// the registered result stage. Depends on asos_pkg.
module asos_ctrl
  import asos_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  input  logic signed [OFS_W-1:0] cfg_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  in_item_t                in_data,
  output ram_req_t                ram_req,
  output stage_t                  stg
);

  // Configuration and run state
  logic signed [OFS_W-1:0] offset_r;
  logic                    in_run_r, in_run_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [POS_W-1:0]        len_r, len_nxt;
  logic                    pass_r, pass_nxt;
  logic                    neg_r, neg_nxt;
  logic [MAG_W-1:0]        mag_r, mag_nxt;
  logic [ZERO_W-1:0]       zeros_r, zeros_nxt;
  stage_t                  stg_r, stg_nxt;

  logic              accept, is_byte, is_flush, start;
  logic [SEC_W-1:0]  sec_eff;
  logic [MAG_W-1:0]  off_bytes, mag_new;
  logic              neg_new, pass_new, short_run;
  logic [MAG_W:0]    lim;
  logic              pass_eff, neg_eff;
  logic [MAG_W-1:0]  mag_eff;
  logic [POS_W-1:0]  pos_eff, pos_plus;
  logic              last, has_prev;

  // Offset register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else if (cfg_valid) begin
      offset_r <= cfg_data;
    end
  end

  always_comb begin
    accept   = in_valid && !in_stall;
    is_byte  = accept && (in_data.op == OP_BYTE);
    is_flush = accept && (in_data.op == OP_FLUSH);
    start    = !in_run_r;

    // Run parameters taken on the first byte
    sec_eff   = (in_data.run_sectors == '0) ? SEC_W'(1) : in_data.run_sectors;
    off_bytes = {offset_r, 2'b00};
    neg_new   = offset_r[OFS_W-1];
    mag_new   = neg_new ? (MAG_W'(0) - off_bytes) : off_bytes;
    // The shift can only reach the run length for runs of up to three sectors
    short_run = (sec_eff < SEC_W'(4));
    lim       = (MAG_W+1)'(sec_eff[1:0]) * (MAG_W+1)'(SECTOR_BYTES);
    pass_new  = (mag_new == '0) ||
                (short_run && ((MAG_W+1)'(mag_new) >= lim)) ||
                (neg_new && (32'(mag_new) > 32'(DELAY_DEPTH)));

    pass_eff = start ? pass_new : pass_r;
    neg_eff  = start ? neg_new  : neg_r;
    mag_eff  = start ? mag_new  : mag_r;
    pos_eff  = start ? '0       : pos_r;
    pos_plus = pos_eff + POS_W'(1);
    // A run is at least one sector long, so its first byte is never its last
    last     = !start && (pos_plus >= len_r);
    has_prev = (pos_eff >= POS_W'(mag_eff));

    // Delay memory access for a negative shift
    ram_req.we    = is_byte && !pass_eff && neg_eff;
    ram_req.waddr = ADDR_W'(pos_eff);
    ram_req.wdata = in_data.sample_byte;
    ram_req.re    = ram_req.we && has_prev;
    ram_req.raddr = ADDR_W'(pos_eff) - ADDR_W'(mag_eff);

    // Defaults: hold state
    in_run_nxt = in_run_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    pass_nxt   = pass_r;
    neg_nxt    = neg_r;
    mag_nxt    = mag_r;
    zeros_nxt  = zeros_r;
    stg_nxt    = '0;

    if (is_byte) begin
      if (start) begin
        len_nxt  = POS_W'(sec_eff) * POS_W'(SECTOR_BYTES);
        pass_nxt = pass_new;
        neg_nxt  = neg_new;
        mag_nxt  = mag_new;
      end
      pos_nxt    = pos_plus;
      in_run_nxt = !last;
      // Owed zeros are dropped by a new run and set at the end of a positive shift
      zeros_nxt  = (last && !pass_eff && !neg_eff) ? ZERO_W'(mag_eff) : '0;

      if (pass_eff) begin
        stg_nxt.valid = 1'b1;
        stg_nxt.data  = in_data.sample_byte;
        stg_nxt.last  = last;
      end else if (!neg_eff) begin
        // Head bytes are dropped
        stg_nxt.valid = has_prev;
        stg_nxt.data  = in_data.sample_byte;
      end else begin
        // Zero padding until the delay line has history
        stg_nxt.valid   = 1'b1;
        stg_nxt.use_mem = has_prev;
        stg_nxt.last    = last;
      end
    end else if (is_flush && start && (zeros_r != '0)) begin
      zeros_nxt     = zeros_r - ZERO_W'(1);
      stg_nxt.valid = 1'b1;
      stg_nxt.last  = (zeros_r == ZERO_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r <= 1'b0;
      pos_r    <= '0;
      len_r    <= '0;
      pass_r   <= 1'b0;
      neg_r    <= 1'b0;
      mag_r    <= '0;
      zeros_r  <= '0;
      stg_r    <= '0;
    end else begin
      in_run_r <= in_run_nxt;
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      pass_r   <= pass_nxt;
      neg_r    <= neg_nxt;
      mag_r    <= mag_nxt;
      zeros_r  <= zeros_nxt;
      stg_r    <= stg_nxt;
    end
  end

  assign stg = stg_r;

endmodule

// ===== src/audio_sample_offset_shifter.sv =====
// Audio sample offset shifter: re-times a CD audio run by a signed sample offset.
// Results pass the registered result stage, then the output queue. One byte per
// cycle while in_stall is low; only a negative shift uses the delay memory.
// Reset (rst_n, synchronous) clears offset, run state and queue; the delay memory
// is not cleared, since each entry is written in a run before it is read.
// Depends on asos_pkg, asos_ctrl, asos_delay_ram, asos_out_fifo.
module audio_sample_offset_shifter
  import asos_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic signed [OFS_W-1:0] cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  in_item_t                in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output out_item_t               out_data
);

  ram_req_t         ram_req;
  stage_t           stg;
  logic [7:0]       rd_data;
  logic [CNT_W-1:0] q_count;
  out_item_t        push_data;

  assign cfg_ready = 1'b1;

  // Hold input while the queue lacks room for the result still in flight
  assign in_stall = ((CNT_W+1)'(q_count) + (CNT_W+1)'(stg.valid)) >=
                    (CNT_W+1)'(FIFO_DEPTH);

  asos_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .ram_req   (ram_req),
    .stg       (stg)
  );

  asos_delay_ram u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

  // Delayed byte or staged value
  always_comb begin
    push_data.out_byte    = stg.use_mem ? rd_data : stg.data;
    push_data.last_of_run = stg.last;
  end

  asos_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (stg.valid),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .count     (q_count)
  );

endmodule
